FILE: hw/rtl/rrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_pkg: shared types and constants of the RESP2 reply stream parser.
// Event, kind and error codes, the result record and the queue sizing.
// ----------------------------------------------------------------------------
package rrsp_pkg;

    // Deepest array nesting that the count stack holds.
    localparam int MAX_DEPTH = 4;
    localparam int SP_W      = $clog2(MAX_DEPTH + 1);

    // Output queue: a byte yields at most two results.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] LEN_NULL = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        EV_START   = 3'd0,
        EV_LENGTH  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_END     = 3'd3,
        EV_NULL    = 3'd4,
        EV_ERROR   = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        K_SIMPLE  = 3'd0,
        K_ERROR   = 3'd1,
        K_INTEGER = 3'd2,
        K_BULK    = 3'd3,
        K_ARRAY   = 3'd4,
        K_UNKNOWN = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIGIT    = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_DEPTH    = 2'd3
    } err_t;

    typedef struct packed {
        event_t      ev;
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] len;
        logic [2:0]  nest;
        logic [2:0]  closed;
        logic        done;
        err_t        err;
    } res_t;

    // Results of one byte: up to two records, in order.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } step_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               not_empty;
        logic               room2;
    } fifo_stat_t;

    function automatic res_t mk_res(
        input event_t      ev,
        input kind_t       kind,
        input logic [7:0]  data,
        input logic [31:0] len,
        input logic [2:0]  nest,
        input logic [2:0]  closed,
        input logic        done,
        input err_t        err
    );
        res_t r;
        r.ev     = ev;
        r.kind   = kind;
        r.data   = data;
        r.len    = len;
        r.nest   = nest;
        r.closed = closed;
        r.done   = done;
        r.err    = err;
        return r;
    endfunction

endpackage

FILE: hw/rtl/rrsp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_core: parser state and array count stack.
// Takes one byte per accepted item, updates the state registers on acceptance and
// presents the zero, one or two result records that the byte causes.
// ----------------------------------------------------------------------------
module rrsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          rx_byte,
    output rrsp_pkg::step_t     step
);

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LINE,
        PH_LEN_EMPTY,
        PH_LEN_DIGITS,
        PH_BULK,
        PH_TRAIL1,
        PH_TRAIL2
    } phase_t;

    localparam int SP_W = rrsp_pkg::SP_W;
    localparam int MD   = rrsp_pkg::MAX_DEPTH;

    phase_t          phase_reg, phase_next;
    rrsp_pkg::kind_t kind_reg, kind_next;
    logic [30:0]     acc_reg, acc_next;
    logic            minus_reg, minus_next;
    logic [30:0]     bulk_reg, bulk_next;
    logic            cr_reg, cr_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [30:0]     stack_reg [MD];

    logic [MD:0]     run;
    logic [MD-1:0]   dec;
    logic [SP_W-1:0] fin_closed;
    logic [SP_W-1:0] fin_sp;
    logic            fin_done;
    logic [SP_W+2:0] nest_ext;
    logic [SP_W+2:0] closed_ext;
    logic [2:0]      nest3;
    logic [2:0]      closed3;

    logic [34:0]     mac;
    logic            is_digit;
    logic            ovf;
    logic            do_finish;
    logic            do_push;
    logic            do_clear;

    // Finishing an element counts down the innermost array; it and each enclosing
    // array in turn close while their count was one. Entries are checked in place.
    always_comb
    begin
        logic in_use;
        logic at_top;
        run        = '0;
        dec        = '0;
        fin_closed = '0;
        for (int i = MD - 1; i >= 0; i--)
        begin
            in_use = SP_W'(i) < sp_reg;
            at_top = (SP_W'(i + 1) >= sp_reg) || run[i + 1];
            run[i] = in_use && (stack_reg[i] == 31'd1) && at_top;
            dec[i] = in_use && (stack_reg[i] != 31'd1) && at_top;
            fin_closed = fin_closed + SP_W'(run[i]);
        end
        fin_sp   = sp_reg - fin_closed;
        fin_done = (fin_sp == '0);
    end

    assign nest_ext   = {3'b000, sp_reg};
    assign closed_ext = {3'b000, fin_closed};
    assign nest3      = nest_ext[2:0];
    assign closed3    = closed_ext[2:0];

    // Decimal accumulate: acc * 10 + digit.
    assign is_digit = (rx_byte >= rrsp_pkg::CH_ZERO) && (rx_byte <= rrsp_pkg::CH_NINE);
    assign mac      = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {31'd0, rx_byte[3:0]};
    assign ovf      = (mac[34:31] != 4'd0);

    always_comb
    begin
        rrsp_pkg::res_t r_fail;
        rrsp_pkg::res_t r_len;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        bulk_next  = bulk_reg;
        cr_next    = cr_reg;
        sp_next    = sp_reg;
        do_finish  = 1'b0;
        do_push    = 1'b0;
        do_clear   = 1'b0;
        step       = '0;

        r_fail = rrsp_pkg::mk_res(rrsp_pkg::EV_ERROR, kind_reg, 8'd0, 32'd0, nest3,
                                  3'd0, 1'b0, rrsp_pkg::ERR_DIGIT);
        r_len  = rrsp_pkg::mk_res(rrsp_pkg::EV_LENGTH, kind_reg, 8'd0, {1'b0, acc_reg},
                                  nest3, 3'd0, 1'b0, rrsp_pkg::ERR_NONE);

        case (phase_reg)
            PH_LINE:
            begin
                if (cr_reg)
                begin
                    if (rx_byte == rrsp_pkg::CH_LF)
                    begin
                        step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_END, kind_reg, 8'd0, 32'd0,
                                                   nest3, closed3, fin_done,
                                                   rrsp_pkg::ERR_NONE);
                        step.cnt  = 2'd1;
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        // A lone CR is payload; a second CR stays pending.
                        step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_PAYLOAD, kind_reg,
                                                   rrsp_pkg::CH_CR, 32'd0, nest3, 3'd0,
                                                   1'b0, rrsp_pkg::ERR_NONE);
                        step.cnt = 2'd1;
                        if (rx_byte != rrsp_pkg::CH_CR)
                        begin
                            cr_next = 1'b0;
                            step.r1 = rrsp_pkg::mk_res(rrsp_pkg::EV_PAYLOAD, kind_reg,
                                                       rx_byte, 32'd0, nest3, 3'd0, 1'b0,
                                                       rrsp_pkg::ERR_NONE);
                            step.cnt = 2'd2;
                        end
                    end
                end
                else if (rx_byte == rrsp_pkg::CH_CR)
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_PAYLOAD, kind_reg, rx_byte,
                                               32'd0, nest3, 3'd0, 1'b0,
                                               rrsp_pkg::ERR_NONE);
                    step.cnt = 2'd1;
                end
            end

            PH_LEN_EMPTY, PH_LEN_DIGITS:
            begin
                if (cr_reg)
                begin
                    if ((rx_byte == rrsp_pkg::CH_LF) && (phase_reg == PH_LEN_DIGITS))
                    begin
                        cr_next = 1'b0;
                        if (minus_reg)
                        begin
                            if (acc_reg != 31'd1)
                            begin
                                step.r0  = r_fail;
                                step.cnt = 2'd1;
                                do_clear = 1'b1;
                            end
                            else
                            begin
                                step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_NULL, kind_reg,
                                                           8'd0, rrsp_pkg::LEN_NULL,
                                                           nest3, closed3, fin_done,
                                                           rrsp_pkg::ERR_NONE);
                                step.cnt  = 2'd1;
                                do_finish = 1'b1;
                            end
                        end
                        else if (kind_reg == rrsp_pkg::K_BULK)
                        begin
                            step.r0    = r_len;
                            step.cnt   = 2'd1;
                            bulk_next  = acc_reg;
                            phase_next = (acc_reg == 31'd0) ? PH_TRAIL1 : PH_BULK;
                        end
                        else if (acc_reg == 31'd0)
                        begin
                            // Empty array: its length and its end together.
                            step.r0 = r_len;
                            step.r1 = rrsp_pkg::mk_res(rrsp_pkg::EV_END, kind_reg, 8'd0,
                                                       32'd0, nest3, closed3, fin_done,
                                                       rrsp_pkg::ERR_NONE);
                            step.cnt  = 2'd2;
                            do_finish = 1'b1;
                        end
                        else if (sp_reg >= SP_W'(MD))
                        begin
                            step.r0     = r_fail;
                            step.r0.err = rrsp_pkg::ERR_DEPTH;
                            step.cnt    = 2'd1;
                            do_clear    = 1'b1;
                        end
                        else
                        begin
                            step.r0  = r_len;
                            step.cnt = 2'd1;
                            do_push  = 1'b1;
                        end
                    end
                    else
                    begin
                        step.r0  = r_fail;
                        step.cnt = 2'd1;
                        do_clear = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    if (ovf)
                    begin
                        step.r0     = r_fail;
                        step.r0.err = rrsp_pkg::ERR_OVERFLOW;
                        step.cnt    = 2'd1;
                        do_clear    = 1'b1;
                    end
                    else
                    begin
                        acc_next   = mac[30:0];
                        phase_next = PH_LEN_DIGITS;
                    end
                end
                else if ((rx_byte == rrsp_pkg::CH_MINUS) && (phase_reg == PH_LEN_EMPTY)
                         && !minus_reg)
                begin
                    minus_next = 1'b1;
                end
                else if ((rx_byte == rrsp_pkg::CH_CR) && (phase_reg == PH_LEN_DIGITS))
                begin
                    cr_next = 1'b1;
                end
                else
                begin
                    step.r0  = r_fail;
                    step.cnt = 2'd1;
                    do_clear = 1'b1;
                end
            end

            PH_BULK:
            begin
                step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_PAYLOAD, kind_reg, rx_byte, 32'd0,
                                           nest3, 3'd0, 1'b0, rrsp_pkg::ERR_NONE);
                step.cnt  = 2'd1;
                bulk_next = bulk_reg - 31'd1;
                if (bulk_reg == 31'd1)
                begin
                    phase_next = PH_TRAIL1;
                end
            end

            PH_TRAIL1:
            begin
                phase_next = PH_TRAIL2;
            end

            PH_TRAIL2:
            begin
                step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_END, kind_reg, 8'd0, 32'd0,
                                           nest3, closed3, fin_done, rrsp_pkg::ERR_NONE);
                step.cnt  = 2'd1;
                do_finish = 1'b1;
            end

            default:
            begin
                acc_next   = '0;
                minus_next = 1'b0;
                cr_next    = 1'b0;
                bulk_next  = '0;
                case (rx_byte)
                    rrsp_pkg::CH_PLUS:
                    begin
                        kind_next  = rrsp_pkg::K_SIMPLE;
                        phase_next = PH_LINE;
                    end
                    rrsp_pkg::CH_MINUS:
                    begin
                        kind_next  = rrsp_pkg::K_ERROR;
                        phase_next = PH_LINE;
                    end
                    rrsp_pkg::CH_COLON:
                    begin
                        kind_next  = rrsp_pkg::K_INTEGER;
                        phase_next = PH_LINE;
                    end
                    rrsp_pkg::CH_DOLLAR:
                    begin
                        kind_next  = rrsp_pkg::K_BULK;
                        phase_next = PH_LEN_EMPTY;
                    end
                    rrsp_pkg::CH_STAR:
                    begin
                        kind_next  = rrsp_pkg::K_ARRAY;
                        phase_next = PH_LEN_EMPTY;
                    end
                    default:
                    begin
                        kind_next = rrsp_pkg::K_UNKNOWN;
                    end
                endcase
                step.r0 = rrsp_pkg::mk_res(rrsp_pkg::EV_START, kind_next, 8'd0, 32'd0,
                                           nest3, 3'd0, 1'b0, rrsp_pkg::ERR_NONE);
                step.cnt = 2'd1;
                // An unknown element ends on its own type byte.
                if (kind_next == rrsp_pkg::K_UNKNOWN)
                begin
                    step.r1 = rrsp_pkg::mk_res(rrsp_pkg::EV_END, kind_next, 8'd0, 32'd0,
                                               nest3, closed3, fin_done,
                                               rrsp_pkg::ERR_NONE);
                    step.cnt  = 2'd2;
                    do_finish = 1'b1;
                end
            end
        endcase

        if (do_finish)
        begin
            sp_next    = fin_sp;
            phase_next = PH_TYPE;
            cr_next    = 1'b0;
        end
        if (do_push)
        begin
            sp_next    = sp_reg + SP_W'(1);
            phase_next = PH_TYPE;
        end
        if (do_clear)
        begin
            phase_next = PH_TYPE;
            kind_next  = rrsp_pkg::K_SIMPLE;
            acc_next   = '0;
            minus_next = 1'b0;
            bulk_next  = '0;
            cr_next    = 1'b0;
            sp_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            kind_reg  <= rrsp_pkg::K_SIMPLE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            bulk_reg  <= '0;
            cr_reg    <= 1'b0;
            sp_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            bulk_reg  <= bulk_next;
            cr_reg    <= cr_next;
            sp_reg    <= sp_next;
        end
    end

    // Count stack entries: written on a push, counted down on an element end.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MD; i++)
        begin
            if (fire && do_push && (sp_reg == SP_W'(i)))
            begin
                stack_reg[i] <= acc_reg;
            end
            else if (fire && do_finish && dec[i])
            begin
                stack_reg[i] <= stack_reg[i] - 31'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/rrsp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsp_out_fifo: result queue of the parser.
// Takes up to two records per cycle and hands out one per cycle.
// ----------------------------------------------------------------------------
module rrsp_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_cnt,
    input  rrsp_pkg::res_t         push0,
    input  rrsp_pkg::res_t         push1,
    input  logic                   pop,
    output rrsp_pkg::res_t         head,
    output rrsp_pkg::fifo_stat_t   stat
);

    localparam int AW = rrsp_pkg::FIFO_AW;
    localparam int CW = rrsp_pkg::FIFO_CW;

    rrsp_pkg::res_t mem [rrsp_pkg::FIFO_DEPTH];
    logic [AW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  wr_p1;

    assign wr_p1      = wr_reg + AW'(1);
    assign wr_next    = wr_reg + AW'(push_cnt);
    assign rd_next    = rd_reg + AW'(pop);
    assign count_next = count_reg + CW'(push_cnt) - CW'(pop);

    assign head           = mem[rd_reg];
    assign stat.count     = count_reg;
    assign stat.not_empty = (count_reg != '0);
    assign stat.room2     = (count_reg <= CW'(rrsp_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_p1] <= push1;
        end
    end

endmodule

FILE: hw/rtl/resp_reply_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_reply_stream_parser: RESP2 reply stream parser, one byte per item.
// Output: the results of a byte are written into the result queue when it is taken.
// Throughput: one byte per cycle; a byte that yields two results (CR payload,
// empty array, unknown type) is absorbed by a four-entry result queue that
// holds off input while fewer than two entries are free.
// Reset: the parser awaits a type byte, no array is open, the queue is empty.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         event_res,
    output logic [2:0]         kind,
    output logic [7:0]         data_byte,
    output logic signed [31:0] length_value,
    output logic [2:0]         nest_level,
    output logic [2:0]         closed_arrays,
    output logic               response_done,
    output logic [1:0]         error_code
);

    logic                 fire;
    logic                 pop;
    logic [1:0]           push_cnt;
    rrsp_pkg::step_t      step;
    rrsp_pkg::res_t       head;
    rrsp_pkg::fifo_stat_t stat;

    // A byte is taken only while the queue has room for both of its possible
    // results, so the parser state never waits on the output side.
    assign in_ready = stat.room2;
    assign fire     = in_valid && in_ready;
    assign push_cnt = fire ? step.cnt : 2'd0;

    // The parser state is the only stage: each byte is decoded against it in
    // the cycle it is accepted and its results go straight into the queue.
    rrsp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (rx_byte),
        .step    (step)
    );

    rrsp_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (step.r0),
        .push1    (step.r1),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    // The head of the queue is the output item.
    assign out_valid     = stat.not_empty;
    assign pop           = out_valid && out_ready;
    assign event_res     = head.ev;
    assign kind          = head.kind;
    assign data_byte     = head.data;
    assign length_value  = $signed(head.len);
    assign nest_level    = head.nest;
    assign closed_arrays = head.closed;
    assign response_done = head.done;
    assign error_code    = head.err;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= rrsp_pkg::FIFO_CW'(rrsp_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // A byte is only taken when both of its results fit.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> stat.count <= rrsp_pkg::FIFO_CW'(rrsp_pkg::FIFO_DEPTH))
        else $error("accepted byte overran the result queue");

    // Error items always carry a reason code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == rrsp_pkg::EV_ERROR)) |-> (error_code != rrsp_pkg::ERR_NONE))
        else $error("error item without a code");

    // A finished reply closes every array that was open around its last element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && response_done) |-> (closed_arrays == nest_level))
        else $error("reply done with arrays still open");

    // Only payload items carry a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res != rrsp_pkg::EV_PAYLOAD)) |-> (data_byte == 8'd0))
        else $error("data byte on a non-payload item");

endmodule
